@@ rtl/lce_pkg.sv @@
package lce_pkg;

  localparam int TIME_W    = 32;
  localparam int LIFE_W    = 16;
  localparam int CFG_W     = 5;
  localparam int REMOVED_W = 5;
  localparam int TYPE_W    = 3;

  localparam logic [TYPE_W-1:0] REQ_GET    = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_SET    = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_TICK   = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_SWEEP  = 3'd4;

  localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOUCH,
    OP_DROP,
    OP_INSERT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     use_idx;
    logic     wr_data;
    logic     evict;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_FINISH
  } state_t;

endpackage

@@ rtl/lce_if.sv @@
interface lce_req_if #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic [lce_pkg::TYPE_W-1:0]    req_type;
  logic [KEY_WIDTH-1:0]          lookup_key;
  logic [VALUE_WIDTH-1:0]        write_value;
  logic [lce_pkg::LIFE_W-1:0]    lifetime;

  modport source(output valid, req_type, lookup_key, write_value, lifetime, input ready);
  modport sink(input valid, req_type, lookup_key, write_value, lifetime, output ready);
endinterface

interface lce_rsp_if #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [VALUE_WIDTH-1:0]        read_value;
  logic                          evicted;
  logic [KEY_WIDTH-1:0]          evicted_key;
  logic [lce_pkg::REMOVED_W-1:0] removed_count;

  modport source(output valid, status, read_value, evicted, evicted_key, removed_count,
                 input ready);
  modport sink(input valid, status, read_value, evicted, evicted_key, removed_count,
               output ready);
endinterface

@@ rtl/lce_cell.sv @@
module lce_cell #(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int RANK_W      = 4,
  parameter int IDX_W       = 4,
  parameter int INDEX       = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lce_pkg::cell_ctl_t            ctl,
  input  logic [KEY_WIDTH-1:0]          b_key,
  input  logic [VALUE_WIDTH-1:0]        b_value,
  input  logic                          b_never,
  input  logic [lce_pkg::TIME_W-1:0]    b_expiry,
  input  logic [lce_pkg::TIME_W-1:0]    b_time,
  input  logic [RANK_W-1:0]             b_ref_rank,
  input  logic [RANK_W-1:0]             b_lru_rank,
  input  logic [IDX_W-1:0]              b_sel_idx,
  input  logic                          found_in,
  input  logic [RANK_W-1:0]             rank_in,
  input  logic [VALUE_WIDTH-1:0]        value_in,
  input  logic                          expired_in,
  input  logic [KEY_WIDTH-1:0]          lru_key_in,
  input  logic                          taken_in,
  output logic                          found_out,
  output logic [RANK_W-1:0]             rank_out,
  output logic [VALUE_WIDTH-1:0]        value_out,
  output logic                          expired_out,
  output logic [KEY_WIDTH-1:0]          lru_key_out,
  output logic                          taken_out
);

  logic                       valid_r, valid_nxt;
  logic [KEY_WIDTH-1:0]       key_r, key_nxt;
  logic [VALUE_WIDTH-1:0]     value_r, value_nxt;
  logic [lce_pkg::TIME_W-1:0] expiry_r, expiry_nxt;
  logic                       never_r, never_nxt;
  logic [RANK_W-1:0]          rank_r, rank_nxt;

  logic match, tgt, expired, lru, cand, pick;

  assign match   = valid_r && (key_r == b_key);
  assign tgt     = ctl.use_idx ? (valid_r && (b_sel_idx == IDX_W'(INDEX))) : match;
  assign expired = !never_r && (b_time > expiry_r);
  assign lru     = valid_r && (rank_r == b_lru_rank);
  // A slot is free if empty, or if it holds the entry being evicted.
  assign cand    = !valid_r || (lru && ctl.evict);
  assign pick    = cand && !taken_in;

  assign found_out   = found_in | tgt;
  assign rank_out    = rank_in | (tgt ? rank_r : '0);
  assign value_out   = value_in | (tgt ? value_r : '0);
  assign expired_out = expired_in | (tgt && expired);
  assign lru_key_out = lru_key_in | (lru ? key_r : '0);
  assign taken_out   = taken_in | cand;

  always_comb begin
    valid_nxt  = valid_r;
    key_nxt    = key_r;
    value_nxt  = value_r;
    expiry_nxt = expiry_r;
    never_nxt  = never_r;
    rank_nxt   = rank_r;
    case (ctl.op)
      lce_pkg::OP_TOUCH: begin
        if (tgt) begin
          rank_nxt = '0;
          if (ctl.wr_data) begin
            value_nxt  = b_value;
            expiry_nxt = b_expiry;
            never_nxt  = b_never;
          end
        end else if (valid_r && (rank_r < b_ref_rank)) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
      end
      lce_pkg::OP_DROP: begin
        if (tgt) begin
          valid_nxt = 1'b0;
        end else if (valid_r && (rank_r > b_ref_rank)) begin
          rank_nxt = rank_r - RANK_W'(1);
        end
      end
      lce_pkg::OP_INSERT: begin
        if (pick) begin
          valid_nxt  = 1'b1;
          key_nxt    = b_key;
          value_nxt  = b_value;
          expiry_nxt = b_expiry;
          never_nxt  = b_never;
          rank_nxt   = '0;
        end else if (lru && ctl.evict) begin
          valid_nxt = 1'b0;
        end else if (valid_r) begin
          rank_nxt = rank_r + RANK_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r    <= key_nxt;
    value_r  <= value_nxt;
    expiry_r <= expiry_nxt;
    never_r  <= never_nxt;
    rank_r   <= rank_nxt;
  end

endmodule

@@ rtl/lru_cache_with_expiry.sv @@
// Fully associative key/value store with least-recently-used replacement
// and a lifetime per entry, built as a row of entry cells.
// in_req carries one request (get, set, remove, one-second tick, sweep);
// out_rsp returns exactly one result per request. A transaction on either
// channel completes when valid and ready are both high. cfg_we/cfg_wdata
// write the capacity register; write it only while the block is idle.
// Get, set, remove, tick and unknown requests are taken while idle; in
// the execute state every cell compares the key and the row updates its
// recency ranks as the request needs. A sweep visits one cell per cycle.
// The result lands in an output register, so a new request is taken
// while a result still waits; if the receiver stalls, the next request
// is held in execute state (a sweep in finish) until the register frees.
// Reset empties the store, clears the time to zero and sets capacity to 16.
module lru_cache_with_expiry #(
  parameter int ENTRIES     = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  lce_req_if.sink                    in_req,
  lce_rsp_if.source                  out_rsp,
  input  logic                       cfg_we,
  input  logic [lce_pkg::CFG_W-1:0]  cfg_wdata
);

  localparam int RANK_W = $clog2(ENTRIES);
  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int CMP_W  = CNT_W + lce_pkg::CFG_W;
  localparam int SW_W   = (CNT_W > lce_pkg::REMOVED_W) ? CNT_W : lce_pkg::REMOVED_W;
  localparam int TW     = lce_pkg::TIME_W;

  lce_pkg::state_t state_r, state_nxt;

  logic [lce_pkg::TYPE_W-1:0] type_r;
  logic [KEY_WIDTH-1:0]       key_r;
  logic [VALUE_WIDTH-1:0]     wval_r;
  logic [lce_pkg::LIFE_W-1:0] life_r;

  logic [lce_pkg::CFG_W-1:0] cap_r;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [TW-1:0]             time_r, time_nxt;
  logic [IDX_W-1:0]          idx_r, idx_nxt;
  logic [SW_W-1:0]           swcnt_r, swcnt_nxt;

  logic                          out_valid_r;
  logic                          out_status_r, out_status_nxt;
  logic [VALUE_WIDTH-1:0]        out_rd_r, out_rd_nxt;
  logic                          out_ev_r, out_ev_nxt;
  logic [KEY_WIDTH-1:0]          out_evkey_r, out_evkey_nxt;
  logic [lce_pkg::REMOVED_W-1:0] out_rm_r, out_rm_nxt;
  logic                          out_load;

  lce_pkg::cell_ctl_t ctl;

  logic                   found_c   [0:ENTRIES];
  logic [RANK_W-1:0]      rank_c    [0:ENTRIES];
  logic [VALUE_WIDTH-1:0] value_c   [0:ENTRIES];
  logic                   expired_c [0:ENTRIES];
  logic [KEY_WIDTH-1:0]   lru_key_c [0:ENTRIES];
  logic                   taken_c   [0:ENTRIES];

  logic            ofree, full, evict;
  logic [CMP_W-1:0] cap_ext, cap_eff;
  logic [TW:0]      exp_sum;
  logic [TW-1:0]    exp_val;
  logic             never;
  logic [RANK_W-1:0] lru_rank;

  assign in_req.ready = (state_r == lce_pkg::ST_IDLE);
  assign ofree        = !out_valid_r || out_rsp.ready;

  assign cap_ext = CMP_W'(cap_r);
  assign cap_eff = (cap_r == '0) ? CMP_W'(1) :
                   ((cap_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_ext);
  assign full    = CMP_W'(count_r) >= cap_eff;
  assign evict   = full && !found_c[ENTRIES];

  assign exp_sum  = {1'b0, time_r} + (TW + 1)'(life_r);
  assign exp_val  = exp_sum[TW] ? '1 : exp_sum[TW-1:0];
  assign never    = (life_r == '0);
  assign lru_rank = RANK_W'(count_r - CNT_W'(1));

  assign found_c[0]   = 1'b0;
  assign rank_c[0]    = '0;
  assign value_c[0]   = '0;
  assign expired_c[0] = 1'b0;
  assign lru_key_c[0] = '0;
  assign taken_c[0]   = 1'b0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lce_cell #(
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH),
      .RANK_W     (RANK_W),
      .IDX_W      (IDX_W),
      .INDEX      (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .b_key      (key_r),
      .b_value    (wval_r),
      .b_never    (never),
      .b_expiry   (exp_val),
      .b_time     (time_r),
      .b_ref_rank (rank_c[ENTRIES]),
      .b_lru_rank (lru_rank),
      .b_sel_idx  (idx_r),
      .found_in   (found_c[g]),
      .rank_in    (rank_c[g]),
      .value_in   (value_c[g]),
      .expired_in (expired_c[g]),
      .lru_key_in (lru_key_c[g]),
      .taken_in   (taken_c[g]),
      .found_out  (found_c[g+1]),
      .rank_out   (rank_c[g+1]),
      .value_out  (value_c[g+1]),
      .expired_out(expired_c[g+1]),
      .lru_key_out(lru_key_c[g+1]),
      .taken_out  (taken_c[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lce_pkg::ST_IDLE: begin
        if (in_req.valid) begin
          state_nxt = lce_pkg::ST_EXEC;
        end
      end
      lce_pkg::ST_EXEC: begin
        if (type_r == lce_pkg::REQ_SWEEP) begin
          state_nxt = lce_pkg::ST_SWEEP;
        end else if (ofree) begin
          state_nxt = lce_pkg::ST_IDLE;
        end
      end
      lce_pkg::ST_SWEEP: begin
        if (idx_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = lce_pkg::ST_FINISH;
        end
      end
      lce_pkg::ST_FINISH: begin
        if (ofree) begin
          state_nxt = lce_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '{op: lce_pkg::OP_NONE, use_idx: 1'b0, wr_data: 1'b0, evict: 1'b0};
    count_nxt      = count_r;
    time_nxt       = time_r;
    idx_nxt        = idx_r;
    swcnt_nxt      = swcnt_r;
    out_load       = 1'b0;
    out_status_nxt = 1'b0;
    out_rd_nxt     = '0;
    out_ev_nxt     = 1'b0;
    out_evkey_nxt  = '0;
    out_rm_nxt     = '0;
    case (state_r)
      lce_pkg::ST_EXEC: begin
        if (type_r == lce_pkg::REQ_SWEEP) begin
          idx_nxt   = '0;
          swcnt_nxt = '0;
        end else if (ofree) begin
          out_load = 1'b1;
          case (type_r)
            lce_pkg::REQ_GET: begin
              if (!found_c[ENTRIES]) begin
                out_status_nxt = 1'b1;
              end else if (expired_c[ENTRIES]) begin
                // An entry found expired is dropped and reported as a miss.
                ctl.op         = lce_pkg::OP_DROP;
                count_nxt      = count_r - CNT_W'(1);
                out_status_nxt = 1'b1;
              end else begin
                ctl.op     = lce_pkg::OP_TOUCH;
                out_rd_nxt = value_c[ENTRIES];
              end
            end
            lce_pkg::REQ_SET: begin
              if (found_c[ENTRIES]) begin
                ctl.op      = lce_pkg::OP_TOUCH;
                ctl.wr_data = 1'b1;
              end else begin
                ctl.op        = lce_pkg::OP_INSERT;
                ctl.evict     = evict;
                out_ev_nxt    = evict;
                out_evkey_nxt = evict ? lru_key_c[ENTRIES] : '0;
                if (!evict) begin
                  count_nxt = count_r + CNT_W'(1);
                end
              end
            end
            lce_pkg::REQ_REMOVE: begin
              if (found_c[ENTRIES]) begin
                ctl.op    = lce_pkg::OP_DROP;
                count_nxt = count_r - CNT_W'(1);
              end else begin
                out_status_nxt = 1'b1;
              end
            end
            lce_pkg::REQ_TICK: begin
              if (time_r != '1) begin
                time_nxt = time_r + TW'(1);
              end
            end
            default: out_status_nxt = 1'b1;
          endcase
        end
      end
      lce_pkg::ST_SWEEP: begin
        ctl.use_idx = 1'b1;
        idx_nxt     = idx_r + IDX_W'(1);
        if (found_c[ENTRIES] && expired_c[ENTRIES]) begin
          ctl.op    = lce_pkg::OP_DROP;
          count_nxt = count_r - CNT_W'(1);
          swcnt_nxt = swcnt_r + SW_W'(1);
        end
      end
      lce_pkg::ST_FINISH: begin
        if (ofree) begin
          out_load   = 1'b1;
          out_rm_nxt = swcnt_r[lce_pkg::REMOVED_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lce_pkg::ST_IDLE;
      cap_r       <= lce_pkg::CAP_RESET;
      count_r     <= '0;
      time_r      <= '0;
      idx_r       <= '0;
      swcnt_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      count_r <= count_nxt;
      time_r  <= time_nxt;
      idx_r   <= idx_nxt;
      swcnt_r <= swcnt_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      type_r <= in_req.req_type;
      key_r  <= in_req.lookup_key;
      wval_r <= in_req.write_value;
      life_r <= in_req.lifetime;
    end
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_rd_r     <= out_rd_nxt;
      out_ev_r     <= out_ev_nxt;
      out_evkey_r  <= out_evkey_nxt;
      out_rm_r     <= out_rm_nxt;
    end
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.read_value    = out_rd_r;
  assign out_rsp.evicted       = out_ev_r;
  assign out_rsp.evicted_key   = out_evkey_r;
  assign out_rsp.removed_count = out_rm_r;

endmodule

@@ verif/lru_cache_with_expiry_tb.sv @@
module lru_cache_with_expiry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [lce_pkg::TYPE_W-1:0] kind;
    logic [31:0]                key;
    logic [31:0]                value;
    logic [lce_pkg::LIFE_W-1:0] life;
  } request_t;

  typedef struct packed {
    logic        status;
    logic [31:0] rd;
    logic        ev;
    logic [31:0] evkey;
    logic [4:0]  removed;
  } reply_t;

  typedef struct {
    request_t req;
    logic     has_known;
    reply_t   known;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [lce_pkg::CFG_W-1:0] cfg_wdata = '0;

  lce_req_if req_ch();
  lce_rsp_if rsp_ch();

  lru_cache_with_expiry dut (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch.sink), .out_rsp(rsp_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  // Shadow copy of the store.
  logic        s_valid [NSLOT];
  logic [31:0] s_key   [NSLOT];
  logic [31:0] s_value [NSLOT];
  logic [31:0] s_exp   [NSLOT];
  logic        s_never [NSLOT];
  int unsigned s_rank  [NSLOT];
  int unsigned s_count;
  logic [31:0] s_now;
  logic [4:0]  s_cap;

  reply_t pending_replies[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic [31:0] key_pool[8];

  function automatic int find_slot(logic [31:0] k);
    for (int i = 0; i < NSLOT; i++)
      if (s_valid[i] && s_key[i] == k) return i;
    return -1;
  endfunction

  function automatic bit stale(int i);
    return !s_never[i] && s_now > s_exp[i];
  endfunction

  function automatic void drop_slot(int i);
    int unsigned r;
    r = s_rank[i];
    s_valid[i] = 1'b0;
    for (int j = 0; j < NSLOT; j++)
      if (s_valid[j] && s_rank[j] > r) s_rank[j]--;
    if (s_count > 0) s_count--;
  endfunction

  function automatic void promote(int i);
    int unsigned r;
    r = s_rank[i];
    for (int j = 0; j < NSLOT; j++)
      if (j != i && s_valid[j] && s_rank[j] < r) s_rank[j]++;
    s_rank[i] = 0;
  endfunction

  function automatic void store_slot(int i, logic [31:0] v, logic [lce_pkg::LIFE_W-1:0] life);
    logic [32:0] sum;
    s_value[i] = v;
    if (life == 0) begin
      s_never[i] = 1'b1;
      s_exp[i] = '0;
    end else begin
      sum = {1'b0, s_now} + life;
      s_never[i] = 1'b0;
      s_exp[i] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    end
  endfunction

  function automatic reply_t cache_predict(request_t r);
    reply_t o;
    int i;
    int lru;
    int unsigned cap;
    o = '0;
    cap = (s_cap == 0) ? 1 : (s_cap > NSLOT ? NSLOT : s_cap);
    case (r.kind)
      lce_pkg::REQ_GET: begin
        i = find_slot(r.key);
        if (i < 0) o.status = 1'b1;
        else if (stale(i)) begin
          drop_slot(i);
          o.status = 1'b1;
        end else begin
          o.rd = s_value[i];
          promote(i);
        end
      end
      lce_pkg::REQ_SET: begin
        i = find_slot(r.key);
        if (i >= 0) begin
          store_slot(i, r.value, r.life);
          promote(i);
        end else begin
          if (s_count >= cap) begin
            lru = -1;
            for (int j = 0; j < NSLOT; j++)
              if (s_valid[j] && (lru < 0 || s_rank[j] > s_rank[lru])) lru = j;
            if (lru >= 0) begin
              o.ev = 1'b1;
              o.evkey = s_key[lru];
              drop_slot(lru);
            end
          end
          i = -1;
          for (int j = 0; j < NSLOT; j++)
            if (!s_valid[j] && i < 0) i = j;
          if (i >= 0) begin
            for (int j = 0; j < NSLOT; j++)
              if (s_valid[j]) s_rank[j]++;
            s_valid[i] = 1'b1;
            s_key[i] = r.key;
            store_slot(i, r.value, r.life);
            s_rank[i] = 0;
            s_count++;
          end
        end
      end
      lce_pkg::REQ_REMOVE: begin
        i = find_slot(r.key);
        if (i < 0) o.status = 1'b1;
        else drop_slot(i);
      end
      lce_pkg::REQ_TICK: if (s_now != 32'hFFFF_FFFF) s_now++;
      lce_pkg::REQ_SWEEP: begin
        for (int j = 0; j < NSLOT; j++)
          if (s_valid[j] && stale(j)) begin
            drop_slot(j);
            o.removed++;
          end
      end
      default: o.status = 1'b1;
    endcase
    return o;
  endfunction

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.lookup_key = '0;
    req_ch.write_value = '0;
    req_ch.lifetime = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      s_valid[i] = 1'b0; s_key[i] = '0; s_value[i] = '0;
      s_exp[i] = '0; s_never[i] = 1'b0; s_rank[i] = 0;
    end
    s_count = 0;
    s_now = '0;
    s_cap = lce_pkg::CAP_RESET;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stalls, and check every transaction against the oldest expectation.
  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      got = '{rsp_ch.status, rsp_ch.read_value, rsp_ch.evicted, rsp_ch.evicted_key,
              rsp_ch.removed_count};
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected st=%0d rd=%h ev=%0d ek=%h rm=%0d, ",
                      "got st=%0d rd=%h ev=%0d ek=%h rm=%0d"},
                     want.status, want.rd, want.ev, want.evkey, want.removed,
                     got.status, got.rd, got.ev, got.evkey, got.removed);
        end
      end
    end
    rsp_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // Valid stays high from one transaction to the next unless the sender idles.
  task automatic send_req(request_t r, logic has_known, reply_t known);
    reply_t p;
    while ($urandom_range(99) < send_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.lookup_key <= r.key;
    req_ch.write_value <= r.value;
    req_ch.lifetime <= r.life;
    do @(posedge clk); while (!req_ch.ready);
    p = cache_predict(r);
    if (has_known && p !== known) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row %h: expected %h, predicted %h", r, known, p);
    end
    pending_replies.insert(pending_replies.size(), p);
  endtask

  task automatic drain;
    req_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (NSLOT + 8) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lce_pkg::CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    s_cap = v;
  endtask

  function automatic request_t random_req();
    request_t r;
    int pick;
    pick = $urandom_range(99);
    r.key = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(7)];
    r.value = $urandom();
    case ($urandom_range(3))
      0: r.life = '0;
      1: r.life = 16'($urandom_range(1, 6));
      2: r.life = 16'($urandom());
      default: r.life = 16'hFFFF;
    endcase
    if (pick < 30) r.kind = lce_pkg::REQ_GET;
    else if (pick < 65) r.kind = lce_pkg::REQ_SET;
    else if (pick < 77) r.kind = lce_pkg::REQ_REMOVE;
    else if (pick < 91) r.kind = lce_pkg::REQ_TICK;
    else if (pick < 97) r.kind = lce_pkg::REQ_SWEEP;
    else r.kind = 3'($urandom_range(5, 7));
    return r;
  endfunction

  row_t dir_rows[$];

  function automatic void add_row(logic [lce_pkg::TYPE_W-1:0] k, logic [31:0] key,
                                  logic [31:0] v, logic [lce_pkg::LIFE_W-1:0] l,
                                  logic hk, reply_t kn);
    row_t w;
    w.req = '{k, key, v, l};
    w.has_known = hk;
    w.known = kn;
    dir_rows.insert(dir_rows.size(), w);
  endfunction

  initial begin
    reply_t ok;
    reply_t miss;
    reply_t none;
    ok = '0;
    miss = '0;
    miss.status = 1'b1;
    none = '0;
    for (int i = 0; i < 8; i++) key_pool[i] = (i < 2) ? {32{i[0]}} : $urandom();

    add_row(lce_pkg::REQ_GET, 32'h0, 32'h0, 16'h0, 1, miss);
    add_row(lce_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'h0, 16'h0, 1, miss);
    add_row(lce_pkg::REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0, 1, ok);
    add_row(lce_pkg::REQ_SET, 32'h0, 32'h0, 16'hFFFF, 1, ok);
    add_row(lce_pkg::REQ_GET, 32'hFFFF_FFFF, 32'h0, 16'h0, 0, none);
    add_row(lce_pkg::REQ_SET, 32'h1234, 32'hA5A5_5A5A, 16'h1, 0, none);
    add_row(lce_pkg::REQ_TICK, 32'h0, 32'h0, 16'h0, 1, ok);
    add_row(lce_pkg::REQ_TICK, 32'h0, 32'h0, 16'h0, 1, ok);
    // Get of an expired entry removes it and reports a miss.
    add_row(lce_pkg::REQ_GET, 32'h1234, 32'h0, 16'h0, 1, miss);
    add_row(lce_pkg::REQ_SET, 32'h55, 32'h1, 16'h1, 0, none);
    add_row(lce_pkg::REQ_SET, 32'h66, 32'h2, 16'h1, 0, none);
    add_row(lce_pkg::REQ_TICK, 32'h0, 32'h0, 16'h0, 0, none);
    add_row(lce_pkg::REQ_TICK, 32'h0, 32'h0, 16'h0, 0, none);
    // Resetting an expired key revives it without eviction.
    add_row(lce_pkg::REQ_SET, 32'h66, 32'h3, 16'h5, 0, none);
    add_row(lce_pkg::REQ_SWEEP, 32'h0, 32'h0, 16'h0, 0, none);
    add_row(lce_pkg::REQ_SWEEP, 32'h0, 32'h0, 16'h0, 1, ok);
    add_row(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1, miss);
    add_row(3'd7, 32'h0, 32'h0, 16'h0, 1, miss);
    add_row(lce_pkg::REQ_REMOVE, 32'h0, 32'h0, 16'h0, 1, ok);
    add_row(lce_pkg::REQ_GET, 32'h66, 32'h0, 16'h0, 0, none);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 17;
    recv_idle = 49;
    foreach (dir_rows[i]) send_req(dir_rows[i].req, dir_rows[i].has_known, dir_rows[i].known);

    // Capacity 1 with a full store: each new key evicts exactly one entry.
    write_capacity(5'd1);
    for (int i = 0; i < 4; i++)
      send_req('{lce_pkg::REQ_SET, 32'h900 + i, i, 16'h0}, 0, none);
    write_capacity(5'd0);
    for (int i = 0; i < 4; i++)
      send_req('{lce_pkg::REQ_SET, 32'hA00 + i, i, 16'h0}, 0, none);
    write_capacity(5'd31);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase % 3)
        0: begin send_idle = 17; recv_idle = 49; end
        1: begin send_idle = 49; recv_idle = 17; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      case (phase)
        1: write_capacity(5'd3);
        2: write_capacity(5'd16);
        3: write_capacity(5'd8);
        4: write_capacity(5'd2);
        5: write_capacity(5'd17);
        default: ;
      endcase
      for (int n = 0; n < 340; n++) send_req(random_req(), 0, none);
    end

    // A final burst of ticks with neither side idling.
    send_idle = 0;
    recv_idle = 0;
    for (int n = 0; n < 20; n++)
      send_req('{lce_pkg::REQ_TICK, 32'h0, 32'h0, 16'h0}, 0, none);

    drain();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
